@@ src/csa_pkg.sv @@
// Package for the causal attention block: sizes, fixed-point widths,
// controller/datapath command and status structs, exp2 table.
// No dependencies.
`default_nettype none
package csa_pkg;

  localparam int MAX_SEQ      = 256;
  localparam int MAX_HEAD_DIM = 64;

  localparam int SEQ_W  = $clog2(MAX_SEQ);
  localparam int ROW_W  = $clog2(MAX_SEQ + 1);
  localparam int DIM_W  = $clog2(MAX_HEAD_DIM);
  localparam int HD_W   = 7;
  localparam int DATA_W = 16;
  localparam int SCL_W  = 16;
  localparam int KA_W   = SEQ_W + DIM_W;

  // dot product, Q14.24, grown over the row
  localparam int DOT_W   = 2 * DATA_W + DIM_W;
  localparam int LO_W    = DOT_W / 2;
  localparam int PHI_W   = DOT_W - LO_W + SCL_W + 1;
  localparam int PLO_W   = LO_W + SCL_W;
  localparam int FULL_W  = DOT_W + SCL_W + 1;
  localparam int SCORE_W = DOT_W + SCL_W - 28;

  localparam int E_W     = 17;
  localparam int Y_W     = SCORE_W + E_W - 12;
  localparam int SUM_W   = E_W + SEQ_W;
  localparam int RECIP_W = 33;
  localparam int W_W     = 18;
  localparam int PROD_W  = W_W + 1 + DATA_W;
  localparam int ACC_W   = 48;

  localparam logic [E_W-1:0] LOG2E_Q16 = 17'd94548;

  typedef struct packed {
    logic             in_we;
    logic             in_store;
    logic [SEQ_W-1:0] in_row;
    logic [DIM_W-1:0] in_dim;
    logic [SEQ_W-1:0] j;
    logic [DIM_W-1:0] k;
    logic             first;
    logic             last;
    logic             ovf;
    logic             sc_issue;
    logic             sc_lo;
    logic             sc_hi;
    logic             sc_fin;
    logic             ex_x;
    logic             ex_y;
    logic             ex_m;
    logic             ex_e;
    logic             div_start;
    logic             ac_w;
    logic             ac_issue;
    logic             out_ld;
    logic [SCL_W-1:0] scale;
  } cmd_t;

  typedef struct packed {
    logic dot_done;
    logic div_done;
    logic ac_busy;
  } sts_t;

  // 2^(-i/16) in Q1.16
  function automatic logic [E_W-1:0] pow2_tab(input logic [4:0] i);
    logic [E_W-1:0] r;
    case (i)
      5'd0:    r = 17'd65536;
      5'd1:    r = 17'd62757;
      5'd2:    r = 17'd60096;
      5'd3:    r = 17'd57548;
      5'd4:    r = 17'd55109;
      5'd5:    r = 17'd52772;
      5'd6:    r = 17'd50535;
      5'd7:    r = 17'd48393;
      5'd8:    r = 17'd46341;
      5'd9:    r = 17'd44376;
      5'd10:   r = 17'd42495;
      5'd11:   r = 17'd40693;
      5'd12:   r = 17'd38968;
      5'd13:   r = 17'd37316;
      5'd14:   r = 17'd35734;
      5'd15:   r = 17'd34219;
      5'd16:   r = 17'd32768;
      default: r = 17'd32768;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/causal_self_attention.sv @@
// Causal attention, one head. Element beats are accepted only while idle; the beat
// that completes row t (hd = effective row length) starts a pass (score MAC,
// exp unit, divider, value MAC), then hd output beats. One row is in flight at a time.
// Reset (async, active low) clears position, control and registers to
// defaults; stores are not cleared. Depends on csa_pkg, csa_ctrl, csa_dp.
`default_nettype none
module causal_self_attention import csa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [SCL_W-1:0]  cfg_data_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [47:0]       s_axis_tdata,  // q_val, k_val, v_val
  input  wire logic              s_axis_tuser,  // seq_first
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [15:0]            m_axis_tdata,  // out_val
  output logic                   m_axis_tlast,  // out_last
  output logic                   m_axis_tuser   // overflow
);

  cmd_t cmd;
  sts_t sts;

  csa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_first_i  (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  csa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .q_i        (s_axis_tdata[15:0]),
    .k_i        (s_axis_tdata[31:16]),
    .v_i        (s_axis_tdata[47:32]),
    .out_val_o  (m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .out_ovf_o  (m_axis_tuser)
  );

endmodule
`default_nettype wire

@@ src/csa_div.sv @@
// Restoring divider, one quotient bit per cycle, for the softmax reciprocal.
// Depends on csa_pkg.
`default_nettype none
module csa_div import csa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [RECIP_W-1:0] num_i,
  input  wire logic [SUM_W-1:0]   den_i,
  output logic                    done_o,
  output logic [RECIP_W-1:0]      quo_o
);

  localparam int CNT_W = $clog2(RECIP_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RECIP_W-1:0] num_q, quo_q;
  logic [SUM_W-1:0]   rem_q, den_q, rem_d;
  logic [SUM_W:0]     cand, diff;
  logic               ge;

  assign cand  = {rem_q, num_q[RECIP_W-1]};
  assign diff  = cand - {1'b0, den_q};
  assign ge    = cand >= {1'b0, den_q};
  assign rem_d = ge ? diff[SUM_W-1:0] : cand[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(RECIP_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[RECIP_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[RECIP_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

@@ src/csa_dp.sv @@
// Attention datapath: key/value/query/score/accumulator memories, MAC
// pipelines, exp table unit, output register. Depends on csa_pkg, csa_div.
`default_nettype none
module csa_dp import csa_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  input  wire logic signed [DATA_W-1:0] q_i,
  input  wire logic signed [DATA_W-1:0] k_i,
  input  wire logic signed [DATA_W-1:0] v_i,
  output logic [DATA_W-1:0]             out_val_o,
  output logic                          out_last_o,
  output logic                          out_ovf_o
);

  localparam int KV_DEPTH = MAX_SEQ * MAX_HEAD_DIM;

  logic [DATA_W-1:0]  kmem [KV_DEPTH];
  logic [DATA_W-1:0]  vmem [KV_DEPTH];
  logic [DATA_W-1:0]  qmem [MAX_HEAD_DIM];
  logic [SCORE_W-1:0] smem [MAX_SEQ];
  logic [ACC_W-1:0]   amem [MAX_HEAD_DIM];

  logic signed [DATA_W-1:0] q_rd_q, k_rd_q, v_rd_q;
  logic [SCORE_W-1:0]       s_rd_q;
  logic signed [ACC_W-1:0]  a_rd_q;

  // score pipeline
  logic                     sc_v1_q, sc_f1_q, sc_l1_q, sc_v2_q, sc_f2_q, sc_l2_q;
  logic                     dot_done_q;
  logic signed [2*DATA_W-1:0] sc_prod_q;
  logic signed [DOT_W-1:0]  dot_q;
  logic [PLO_W-1:0]         plo_q;
  logic signed [PHI_W-1:0]  phi_q;
  logic signed [FULL_W-1:0] phi_ext;
  logic [FULL_W-1:0]        sc_full;
  logic [SCORE_W-1:0]       sc_score, mx_q;

  // exp unit
  logic [SCORE_W-1:0]       x_q;
  logic [SCORE_W+E_W-1:0]   y_full;
  logic [Y_W-1:0]           y_q;
  logic [Y_W-17:0]          y_n;
  logic [4:0]               ti;
  logic [E_W-1:0]           ta, tb, tdiff, m_q;
  logic [24:0]              dm;
  logic [4:0]               n_q;
  logic                     ez_q;
  logic [E_W:0]             e_rnd;
  logic [E_W-1:0]           e_val;
  logic [SUM_W-1:0]         sum_q;

  // reciprocal, weight, accumulate
  logic                     div_done;
  logic [RECIP_W-1:0]       recip;
  logic [RECIP_W-1:0]       div_num;
  logic [SUM_W-1:0]         div_den;
  logic [E_W+RECIP_W-1:0]   w_full;
  logic [W_W-1:0]           w_q;
  logic                     ac_v1_q, ac_f1_q, ac_v2_q;
  logic [DIM_W-1:0]         ac_d1_q, ac_d2_q;
  logic signed [PROD_W-1:0] ac_prod_q;
  logic signed [ACC_W-1:0]  ac_base_q;

  // output
  logic signed [ACC_W-1:0]   o_rnd;
  logic signed [ACC_W-17:0]  o_sh;
  logic [DATA_W-1:0]         o_sat;
  logic [DATA_W-1:0]         out_val_q;
  logic                      out_last_q, out_ovf_q;

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_we && cmd_i.in_store) begin
      kmem[{cmd_i.in_row, cmd_i.in_dim}] <= k_i;
      vmem[{cmd_i.in_row, cmd_i.in_dim}] <= v_i;
    end
    k_rd_q <= kmem[{cmd_i.j, cmd_i.k}];
    v_rd_q <= vmem[{cmd_i.j, cmd_i.k}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_we) qmem[cmd_i.in_dim] <= q_i;
    q_rd_q <= qmem[cmd_i.k];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sc_fin) smem[cmd_i.j] <= sc_score;
    else if (cmd_i.ex_e) smem[cmd_i.j] <= SCORE_W'(e_val);
    s_rd_q <= smem[cmd_i.j];
  end

  always_ff @(posedge clk_i) begin
    if (ac_v2_q) amem[ac_d2_q] <= ac_base_q + ACC_W'(ac_prod_q);
    a_rd_q <= amem[cmd_i.k];
  end

  // score arithmetic
  assign phi_ext  = FULL_W'(phi_q);
  assign sc_full  = (phi_ext << LO_W) + FULL_W'(plo_q) + (FULL_W'(1) << 27);
  assign sc_score = sc_full[28 +: SCORE_W];

  // exp arithmetic
  assign y_full = x_q * LOG2E_Q16 + (SCORE_W+E_W)'(2048);
  assign y_n    = y_q[Y_W-1:16];
  assign ti     = {1'b0, y_q[15:12]};
  assign ta     = pow2_tab(ti);
  assign tb     = pow2_tab(ti + 5'd1);
  assign tdiff  = ta - tb;
  assign dm     = tdiff[11:0] * y_q[11:0] + 25'd2048;
  assign e_rnd  = ({1'b0, m_q} + ((18'(1) << n_q) >> 1)) >> n_q;
  assign e_val  = ez_q ? '0 : e_rnd[E_W-1:0];

  assign div_num = {1'b1, 32'd0} + RECIP_W'(sum_q >> 1);
  assign div_den = (sum_q == '0) ? SUM_W'(1) : sum_q;
  assign w_full  = s_rd_q[E_W-1:0] * recip + (E_W+RECIP_W)'(32768);

  assign o_rnd = a_rd_q + ACC_W'(32768);
  assign o_sh  = o_rnd[ACC_W-1:16];
  always_comb begin
    if (o_sh > $signed((ACC_W-16)'(32767)))       o_sat = 16'h7fff;
    else if (o_sh < -$signed((ACC_W-16)'(32768))) o_sat = 16'h8000;
    else                                          o_sat = o_sh[DATA_W-1:0];
  end

  csa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (recip)
  );

  // pipeline control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v1_q    <= 1'b0;
      sc_v2_q    <= 1'b0;
      dot_done_q <= 1'b0;
      ac_v1_q    <= 1'b0;
      ac_v2_q    <= 1'b0;
    end else begin
      sc_v1_q    <= cmd_i.sc_issue;
      sc_v2_q    <= sc_v1_q;
      dot_done_q <= sc_v2_q && sc_l2_q;
      ac_v1_q    <= cmd_i.ac_issue;
      ac_v2_q    <= ac_v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_f1_q   <= cmd_i.first;
    sc_l1_q   <= cmd_i.last;
    sc_f2_q   <= sc_f1_q;
    sc_l2_q   <= sc_l1_q;
    sc_prod_q <= q_rd_q * k_rd_q;
    if (sc_v2_q) dot_q <= sc_f2_q ? DOT_W'(sc_prod_q) : dot_q + DOT_W'(sc_prod_q);
    if (cmd_i.sc_lo) plo_q <= dot_q[LO_W-1:0] * cmd_i.scale;
    if (cmd_i.sc_hi) phi_q <= $signed(dot_q[DOT_W-1:LO_W]) * $signed({1'b0, cmd_i.scale});
    if (cmd_i.sc_fin && (cmd_i.first || $signed(sc_score) > $signed(mx_q))) mx_q <= sc_score;

    if (cmd_i.ex_x) x_q <= mx_q - s_rd_q;
    if (cmd_i.ex_y) y_q <= y_full[12 +: Y_W];
    if (cmd_i.ex_m) begin
      m_q  <= ta - E_W'(dm >> 12);
      n_q  <= y_n[4:0];
      ez_q <= y_n > (Y_W-16)'(16);
    end
    if (cmd_i.ex_e) sum_q <= (cmd_i.first ? '0 : sum_q) + SUM_W'(e_val);

    if (cmd_i.ac_w) w_q <= w_full[16 +: W_W];
    ac_d1_q   <= cmd_i.k;
    ac_f1_q   <= cmd_i.first;
    ac_d2_q   <= ac_d1_q;
    ac_prod_q <= $signed({1'b0, w_q}) * v_rd_q;
    ac_base_q <= ac_f1_q ? '0 : a_rd_q;

    if (cmd_i.out_ld) begin
      out_val_q  <= cmd_i.ovf ? '0 : o_sat;
      out_last_q <= cmd_i.last;
      out_ovf_q  <= cmd_i.ovf;
    end
  end

  assign sts_o.dot_done = dot_done_q;
  assign sts_o.div_done = div_done;
  assign sts_o.ac_busy  = ac_v1_q || ac_v2_q;

  assign out_val_o  = out_val_q;
  assign out_last_o = out_last_q;
  assign out_ovf_o  = out_ovf_q;

endmodule
`default_nettype wire

@@ src/csa_ctrl.sv @@
// Attention controller: configuration registers, row/dim position,
// sequencing of score, exp, reciprocal, accumulate and output passes.
// Depends on csa_pkg.
`default_nettype none
module csa_ctrl import csa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [SCL_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  input  wire logic              in_first_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cmd_t                   cmd_o,
  input  wire sts_t              sts_i
);

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_SC_ISSUE = 20'h00002,
    S_SC_WAIT  = 20'h00004,
    S_SC_LO    = 20'h00008,
    S_SC_HI    = 20'h00010,
    S_SC_FIN   = 20'h00020,
    S_EX_RD    = 20'h00040,
    S_EX_X     = 20'h00080,
    S_EX_Y     = 20'h00100,
    S_EX_M     = 20'h00200,
    S_EX_E     = 20'h00400,
    S_DIV_GO   = 20'h00800,
    S_DIV_WAIT = 20'h01000,
    S_AC_RD    = 20'h02000,
    S_AC_W     = 20'h04000,
    S_AC_ISSUE = 20'h08000,
    S_AC_WAIT  = 20'h10000,
    S_OUT_RD   = 20'h20000,
    S_OUT_LD   = 20'h40000,
    S_OUT_WAIT = 20'h80000
  } state_e;

  localparam logic CFG_HEAD_DIM = 1'b0;
  localparam logic CFG_SCALE    = 1'b1;

  state_e st_q, st_d;
  logic [HD_W-1:0]  hd_q, hd_eff;
  logic [SCL_W-1:0] scale_q;
  logic [ROW_W-1:0] row_q, row_d, row_eff;
  logic [DIM_W-1:0] dim_q, dim_d, dim_eff;
  logic [SEQ_W-1:0] t_q, t_d, j_q, j_d;
  logic [DIM_W-1:0] k_q, k_d;
  logic             ovf_q, ovf_d;
  logic             in_fire, last_k, last_j;

  assign hd_eff = (hd_q == '0) ? HD_W'(1) :
                  (hd_q > HD_W'(MAX_HEAD_DIM)) ? HD_W'(MAX_HEAD_DIM) : hd_q;
  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT_WAIT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign row_eff     = in_first_i ? '0 : row_q;
  assign dim_eff     = in_first_i ? '0 : dim_q;
  assign last_k      = (HD_W'(k_q) + HD_W'(1)) == hd_eff;
  assign last_j      = (j_q == t_q);

  always_comb begin
    st_d  = st_q;
    row_d = row_q;
    dim_d = dim_q;
    t_d   = t_q;
    j_d   = j_q;
    k_d   = k_q;
    ovf_d = ovf_q;
    cmd_o = '0;
    cmd_o.in_row   = row_eff[SEQ_W-1:0];
    cmd_o.in_dim   = dim_eff;
    cmd_o.in_store = row_eff < ROW_W'(MAX_SEQ);
    cmd_o.j        = j_q;
    cmd_o.k        = k_q;
    cmd_o.ovf      = ovf_q;
    cmd_o.last     = last_k;
    cmd_o.scale    = scale_q;
    case (st_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.in_we = 1'b1;
          row_d = row_eff;
          if ((HD_W'(dim_eff) + HD_W'(1)) < hd_eff) begin
            dim_d = dim_eff + DIM_W'(1);
          end else begin
            dim_d = '0;
            j_d   = '0;
            k_d   = '0;
            if (row_eff >= ROW_W'(MAX_SEQ)) begin
              ovf_d = 1'b1;
              st_d  = S_OUT_RD;
            end else begin
              ovf_d = 1'b0;
              t_d   = row_eff[SEQ_W-1:0];
              row_d = row_eff + ROW_W'(1);
              st_d  = S_SC_ISSUE;
            end
          end
        end
      end
      S_SC_ISSUE: begin
        cmd_o.sc_issue = 1'b1;
        cmd_o.first    = (k_q == '0);
        if (last_k) begin
          k_d  = '0;
          st_d = S_SC_WAIT;
        end else begin
          k_d = k_q + DIM_W'(1);
        end
      end
      S_SC_WAIT: if (sts_i.dot_done) st_d = S_SC_LO;
      S_SC_LO: begin
        cmd_o.sc_lo = 1'b1;
        st_d = S_SC_HI;
      end
      S_SC_HI: begin
        cmd_o.sc_hi = 1'b1;
        st_d = S_SC_FIN;
      end
      S_SC_FIN: begin
        cmd_o.sc_fin = 1'b1;
        cmd_o.first  = (j_q == '0);
        if (last_j) begin
          j_d  = '0;
          st_d = S_EX_RD;
        end else begin
          j_d  = j_q + SEQ_W'(1);
          st_d = S_SC_ISSUE;
        end
      end
      S_EX_RD: st_d = S_EX_X;
      S_EX_X: begin
        cmd_o.ex_x = 1'b1;
        st_d = S_EX_Y;
      end
      S_EX_Y: begin
        cmd_o.ex_y = 1'b1;
        st_d = S_EX_M;
      end
      S_EX_M: begin
        cmd_o.ex_m = 1'b1;
        st_d = S_EX_E;
      end
      S_EX_E: begin
        cmd_o.ex_e  = 1'b1;
        cmd_o.first = (j_q == '0);
        if (last_j) begin
          j_d  = '0;
          st_d = S_DIV_GO;
        end else begin
          j_d  = j_q + SEQ_W'(1);
          st_d = S_EX_RD;
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        st_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (sts_i.div_done) st_d = S_AC_RD;
      S_AC_RD: st_d = S_AC_W;
      S_AC_W: begin
        cmd_o.ac_w = 1'b1;
        st_d = S_AC_ISSUE;
      end
      S_AC_ISSUE: begin
        cmd_o.ac_issue = 1'b1;
        cmd_o.first    = (j_q == '0);
        if (last_k) begin
          k_d  = '0;
          st_d = S_AC_WAIT;
        end else begin
          k_d = k_q + DIM_W'(1);
        end
      end
      S_AC_WAIT: begin
        // hold until the last accumulator write has landed
        if (!sts_i.ac_busy) begin
          if (last_j) begin
            st_d = S_OUT_RD;
          end else begin
            j_d  = j_q + SEQ_W'(1);
            st_d = S_AC_RD;
          end
        end
      end
      S_OUT_RD: st_d = S_OUT_LD;
      S_OUT_LD: begin
        cmd_o.out_ld = 1'b1;
        st_d = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready_i) begin
          if (last_k) begin
            k_d  = '0;
            st_d = S_IDLE;
          end else begin
            k_d  = k_q + DIM_W'(1);
            st_d = S_OUT_RD;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      hd_q    <= HD_W'(MAX_HEAD_DIM);
      scale_q <= 16'd8192;
      row_q   <= '0;
      dim_q   <= '0;
      t_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      ovf_q   <= 1'b0;
    end else begin
      st_q  <= st_d;
      row_q <= row_d;
      dim_q <= dim_d;
      t_q   <= t_d;
      j_q   <= j_d;
      k_q   <= k_d;
      ovf_q <= ovf_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEAD_DIM: hd_q    <= cfg_data_i[HD_W-1:0];
          CFG_SCALE:    scale_q <= cfg_data_i;
          default:      ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/causal_self_attention_checker.sv @@
// Checker for the causal attention block: mirrors its key/value stores and
// computes each output row from the accepted element beats. Uses csa_pkg.
`timescale 1ns / 100ps
module causal_self_attention_checker import csa_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [SCL_W-1:0] cfg_data_i,
  input  wire logic             s_axis_tvalid,
  input  wire logic             s_axis_tready,
  input  wire logic [47:0]      s_axis_tdata,
  input  wire logic             s_axis_tuser,
  input  wire logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  input  wire logic [15:0]      m_axis_tdata,
  input  wire logic             m_axis_tlast,
  input  wire logic             m_axis_tuser,
  output int                    errors_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    overflow_rows_o
);

  localparam logic REG_HEAD_DIM = 1'b0;
  localparam logic REG_SCALE    = 1'b1;

  typedef struct packed {
    logic [15:0] val;
    logic        last;
    logic        ovf;
  } out_elem_t;

  out_elem_t   expected_q[$];
  logic [6:0]  row_len;
  logic [15:0] scale;
  int          row_pos;
  int          dim_pos;
  logic signed [15:0] key_mem [MAX_SEQ][MAX_HEAD_DIM];
  logic signed [15:0] val_mem [MAX_SEQ][MAX_HEAD_DIM];
  logic signed [15:0] q_row [MAX_HEAD_DIM];

  // 2^(-i/16), Q1.16
  longint exp2_lut [17] = '{65536, 62757, 60096, 57548, 55109, 52772, 50535, 48393,
                            46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  function automatic longint neg_exp(longint x);
    longint y, n, f, i, rem, m;
    y = (x * 94548 + 2048) >>> 12;
    n = y >>> 16;
    if (n > 16) return 0;
    f = y & 16'hFFFF;
    i = f >>> 12;
    rem = f & 12'hFFF;
    m = exp2_lut[i] - (((exp2_lut[i] - exp2_lut[i + 1]) * rem + 2048) >>> 12);
    return (m + ((longint'(1) << n) >>> 1)) >>> n;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors_o++;
  endtask

  // Take one element beat; on a completed row queue its output row.
  task automatic attend(logic signed [15:0] q, logic signed [15:0] k,
                        logic signed [15:0] v, logic first);
    int hd, d, t;
    longint dot, mx, sum, recip, w, r;
    longint sc [MAX_SEQ];
    longint acc [MAX_HEAD_DIM];
    out_elem_t o;
    hd = (row_len < 1) ? 1 : (row_len > MAX_HEAD_DIM) ? MAX_HEAD_DIM : int'(row_len);
    if (first) begin
      row_pos = 0;
      dim_pos = 0;
    end
    d = (dim_pos >= MAX_HEAD_DIM) ? MAX_HEAD_DIM - 1 : dim_pos;
    q_row[d] = q;
    if (row_pos < MAX_SEQ) begin
      key_mem[row_pos][d] = k;
      val_mem[row_pos][d] = v;
    end
    if (d + 1 < hd) begin
      dim_pos = d + 1;
      return;
    end
    dim_pos = 0;
    if (row_pos >= MAX_SEQ) begin
      for (int i = 0; i < hd; i++) begin
        o.val = '0; o.last = (i + 1 == hd); o.ovf = 1'b1;
        expected_q.push_back(o);
      end
      row_pos = MAX_SEQ;
      overflow_rows_o++;
      return;
    end
    t = row_pos;
    mx = 0;
    for (int j = 0; j <= t; j++) begin
      dot = 0;
      for (int i = 0; i < hd; i++) dot += longint'(q_row[i]) * longint'(key_mem[j][i]);
      sc[j] = (dot * longint'(scale) + (longint'(1) << 27)) >>> 28;
      if (j == 0 || sc[j] > mx) mx = sc[j];
    end
    sum = 0;
    for (int j = 0; j <= t; j++) begin
      sc[j] = neg_exp(mx - sc[j]);
      sum += sc[j];
    end
    if (sum == 0) sum = 1;
    recip = ((longint'(1) << 32) + (sum >>> 1)) / sum;
    for (int i = 0; i < hd; i++) acc[i] = 0;
    for (int j = 0; j <= t; j++) begin
      w = (sc[j] * recip + 32768) >>> 16;
      for (int i = 0; i < hd; i++) acc[i] += w * longint'(val_mem[j][i]);
    end
    for (int i = 0; i < hd; i++) begin
      r = (acc[i] + 32768) >>> 16;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      o.val = r[15:0]; o.last = (i + 1 == hd); o.ovf = 1'b0;
      expected_q.push_back(o);
    end
    row_pos = t + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len = 7'd64;
      scale = 16'd8192;
      row_pos = 0;
      dim_pos = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_HEAD_DIM) row_len = cfg_data_i[6:0];
        else if (cfg_idx_i == REG_SCALE) scale = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        attend(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32], s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        out_elem_t e;
        checked_o++;
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected beat val=%h", m_axis_tdata));
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata !== e.val)
            report($sformatf("out_val %h, want %h", m_axis_tdata, e.val));
          if (m_axis_tlast !== e.last)
            report($sformatf("tlast %b, want %b", m_axis_tlast, e.last));
          if (m_axis_tuser !== e.ovf)
            report($sformatf("overflow %b, want %b", m_axis_tuser, e.ovf));
        end
      end
    end
    pending_o = expected_q.size();
  end

  initial begin
    errors_o = 0;
    checked_o = 0;
    overflow_rows_o = 0;
    pending_o = 0;
  end

endmodule

@@ tb/sv/causal_self_attention_test.sv @@
// Top of the causal attention testbench: clock, reset, register writes and
// element stimulus; verdict from causal_self_attention_checker. Uses csa_pkg.
`timescale 1ns / 100ps
module causal_self_attention_test;
  import csa_pkg::*;

  localparam logic REG_HEAD_DIM = 1'b0;
  localparam logic REG_SCALE    = 1'b1;
  localparam int   CYCLE_LIMIT  = 4000000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = 1'b0;
  logic [SCL_W-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [47:0]      s_axis_tdata = '0;  // q_val, k_val, v_val
  logic             s_axis_tuser = 1'b0;  // seq_first
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;  // out_val
  logic             m_axis_tlast;  // out_last
  logic             m_axis_tuser;  // overflow

  int   errors, pending, checked, overflow_rows;
  int   cycles = 0;
  int   stall = 0;
  logic quiet = 1'b0;

  causal_self_attention dut (.*);

  causal_self_attention_checker attn_monitor (
    .*,
    .errors_o(errors),
    .pending_o(pending),
    .checked_o(checked),
    .overflow_rows_o(overflow_rows)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, none in the quiet tail
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall <= 0;
    end else if (stall != 0) begin
      stall <= stall - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall <= $urandom_range(0, 15);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold valid across back-to-back beats; drop it only in a gap
  task automatic send_elem(logic [15:0] q, logic [15:0] k, logic [15:0] v, logic first);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {v, k, q};
    s_axis_tuser <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_rows(int hd, int rows);
    for (int r = 0; r < rows; r++)
      for (int d = 0; d < hd; d++)
        send_elem(rand_val(), rand_val(), rand_val(), (r == 0 && d == 0));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // extremes on short rows, then a restart in the middle of a row
    write_reg(REG_HEAD_DIM, 16'd4);
    write_reg(REG_SCALE, 16'd65535);
    for (int d = 0; d < 4; d++) send_elem(16'h7FFF, 16'h7FFF, 16'h7FFF, d == 0);
    for (int d = 0; d < 4; d++) send_elem(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_elem(16'h1234, 16'h8000, 16'h7FFF, 1'b0);
    send_elem(16'h8000, 16'h7FFF, 16'h0000, 1'b0);
    send_rows(4, 2);
    // shrink the row length with a partial row waiting
    send_elem(16'h0FFF, 16'hF000, 16'h7FFF, 1'b0);
    send_elem(16'h8000, 16'h0001, 16'hFFFF, 1'b0);
    drain();
    write_reg(REG_HEAD_DIM, 16'd2);
    send_elem(16'h7FFF, 16'h8000, 16'h8000, 1'b0);
    drain();

    // zero length acts as one; a run of one-element rows
    write_reg(REG_HEAD_DIM, 16'd0);
    write_reg(REG_SCALE, 16'd8192);
    send_rows(1, 20);
    drain();

    // length above the maximum clamps, then the full length
    write_reg(REG_HEAD_DIM, 16'd127);
    write_reg(REG_SCALE, 16'd0);
    send_rows(64, 1);
    drain();
    write_reg(REG_HEAD_DIM, 16'd64);
    write_reg(REG_SCALE, 16'($urandom()));
    send_rows(64, 1);
    drain();

    for (int p = 0; p < 6; p++) begin
      int hd, rows;
      hd = $urandom_range(1, 8);
      rows = $urandom_range(1, 4);
      if (p >= 4) quiet = 1'b1;
      write_reg(REG_HEAD_DIM, 16'(hd));
      write_reg(REG_SCALE, (p % 4 == 0) ? 16'hFFFF : 16'($urandom()));
      for (int r = 0; r < rows; r++)
        for (int d = 0; d < hd; d++)
          // occasional stray restart breaks a row
          send_elem(rand_val(), rand_val(), rand_val(),
                    (r == 0 && d == 0) || $urandom_range(0, 24) == 0);
      drain();
    end

    $display("covered %0d output beats, %0d overflow rows, row lengths 1 to 64",
             checked, overflow_rows);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
